[rtl/core/cfr_pkg.sv]
// shared types, constants and codes for the clock frame replacement block
package cfr_pkg;

	// table geometry
	localparam int NUM_FRAMES = 64;
	localparam int PROC_BITS  = 8;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_ACTIVE = 1'd1;

	// request kinds
	localparam logic [1:0] KIND_ACCESS  = 2'd0;
	localparam logic [1:0] KIND_FAULT   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// response status codes
	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_FREE     = 2'd1;
	localparam logic [1:0] STATUS_REPLACED = 2'd2;
	localparam logic [1:0] STATUS_NO_VICT  = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic [PROC_BITS-1:0] proc_id;
		logic [FRAME_W-1:0]   frame_no;
		logic                 is_write;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] granted_frame;
		logic [1:0]         status;
		logic               needs_swap_out;
	} rsp_t;

	// per-frame table entry, meaningful only while the frame is busy
	typedef struct packed {
		logic [PROC_BITS-1:0] owner;
		logic                 used_f;
		logic                 mod_f;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC_RD,
		S_ACC_WR,
		S_FREE,
		S_SCAN,
		S_REL,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic acc_rd;
		logic acc_wr;
		logic run_free;
		logic run_scan;
		logic run_rel;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic free_hit;
		logic free_last;
		logic scan_end;
		logic rel_end;
		logic out_free;
	} sts_t;

endpackage

[rtl/core/cfr_ctrl.sv]
// controller state machine that sequences access, fault and release transactions
module cfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_kind,
	output logic          req_ready,
	input  cfr_pkg::sts_t sts,
	output cfr_pkg::cmd_t cmd
);

	cfr_pkg::state_t state_q;
	cfr_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cfr_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req_kind)
						cfr_pkg::KIND_ACCESS:  state_d = cfr_pkg::S_ACC_RD;
						cfr_pkg::KIND_FAULT:   state_d = cfr_pkg::S_FREE;
						cfr_pkg::KIND_RELEASE: state_d = cfr_pkg::S_REL;
						default:               state_d = cfr_pkg::S_RESP;
					endcase
				end
			end
			cfr_pkg::S_ACC_RD: state_d = cfr_pkg::S_ACC_WR;
			cfr_pkg::S_ACC_WR: state_d = cfr_pkg::S_RESP;
			cfr_pkg::S_FREE: begin
				if (sts.free_hit) begin
					state_d = cfr_pkg::S_RESP;
				end else if (sts.free_last) begin
					state_d = cfr_pkg::S_SCAN;
				end
			end
			cfr_pkg::S_SCAN: begin
				if (sts.scan_end) begin
					state_d = cfr_pkg::S_RESP;
				end
			end
			cfr_pkg::S_REL: begin
				if (sts.rel_end) begin
					state_d = cfr_pkg::S_RESP;
				end
			end
			cfr_pkg::S_RESP: begin
				if (sts.out_free) begin
					state_d = cfr_pkg::S_IDLE;
				end
			end
			default: state_d = cfr_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			cfr_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			cfr_pkg::S_ACC_RD: cmd.acc_rd   = 1'b1;
			cfr_pkg::S_ACC_WR: cmd.acc_wr   = 1'b1;
			cfr_pkg::S_FREE:   cmd.run_free = 1'b1;
			cfr_pkg::S_SCAN:   cmd.run_scan = 1'b1;
			cfr_pkg::S_REL:    cmd.run_rel  = 1'b1;
			cfr_pkg::S_RESP:   cmd.load_out = sts.out_free;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/cfr_dp.sv]
// datapath: frame table, busy bits, clock hand, scan pipeline and response register
module cfr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfr_pkg::cmd_t                 cmd,
	output cfr_pkg::sts_t                 sts,
	input  cfr_pkg::req_t                 req,
	input  logic                          replace_mode,
	input  logic [cfr_pkg::FRAME_W-1:0]   last_frame,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cfr_pkg::rsp_t                 rsp
);

	localparam int FW = cfr_pkg::FRAME_W;

	// frame table memory and busy bits
	cfr_pkg::entry_t                    mem [cfr_pkg::NUM_FRAMES];
	cfr_pkg::entry_t                    rd_q;
	logic [cfr_pkg::NUM_FRAMES-1:0]     busy_q;
	logic [FW-1:0]                      hand_q;

	// transaction and walk registers
	cfr_pkg::req_t                      req_q;
	cfr_pkg::rsp_t                      res_q;
	cfr_pkg::rsp_t                      rsp_q;
	logic                               rsp_valid_q;
	logic [FW-1:0]                      idx_q;
	logic [FW-1:0]                      cnt_q;
	logic [1:0]                         sweep_q;
	logic                               issue_q;

	// evaluation stage
	logic                               valid_s1;
	logic [FW-1:0]                      pos_s1;
	logic [1:0]                         sweep_s1;
	logic                               last_s1;

	// write bypass
	logic                               byp_valid_q;
	logic [FW-1:0]                      byp_addr_q;
	cfr_pkg::entry_t                    byp_data_q;

	logic                               we;
	logic [FW-1:0]                      waddr;
	cfr_pkg::entry_t                    wdata;
	logic [FW-1:0]                      rd_addr;
	cfr_pkg::entry_t                    ent;
	cfr_pkg::entry_t                    fresh;
	logic                               issue;
	logic                               free_hit;
	logic                               free_last;
	logic                               scan_last_issue;
	logic                               rel_last_issue;
	logic [FW-1:0]                      idx_wrap;
	logic [FW-1:0]                      pos_next;
	logic [FW-1:0]                      hand_start;
	logic                               cand;
	logic                               take;
	logic                               clr;
	logic                               eval_scan;
	logic                               victim;
	logic                               scan_end;
	logic                               rel_hit;
	logic                               acc_ok;

	// walk control
	always_comb begin
		issue           = (cmd.run_scan | cmd.run_rel) & issue_q;
		free_hit        = !busy_q[idx_q];
		free_last       = (idx_q == last_frame);
		scan_last_issue = (sweep_q == 2'd3) && (cnt_q == last_frame);
		rel_last_issue  = (idx_q == FW'(cfr_pkg::NUM_FRAMES - 1));
		idx_wrap        = (idx_q == last_frame) ? '0 : idx_q + 1'b1;
		pos_next        = (pos_s1 == last_frame) ? '0 : pos_s1 + 1'b1;
		hand_start      = (hand_q <= last_frame) ? hand_q : '0;
		fresh           = '{owner: req_q.proc_id, used_f: 1'b0, mod_f: 1'b0};
	end

	// victim selection on the evaluated frame
	always_comb begin
		if (byp_valid_q && (byp_addr_q == pos_s1)) begin
			ent = byp_data_q;
		end else begin
			ent = rd_q;
		end
		cand = busy_q[pos_s1] && (ent.owner == req_q.proc_id);
		if (!replace_mode) begin
			take = !ent.used_f;
			clr  = 1'b1;
		end else if (sweep_s1[0]) begin
			take = !ent.used_f && ent.mod_f;
			clr  = 1'b1;
		end else begin
			take = !ent.used_f && !ent.mod_f;
			clr  = 1'b0;
		end
		eval_scan = cmd.run_scan && valid_s1;
		victim    = eval_scan && cand && take;
		scan_end  = victim || (eval_scan && last_s1);
		rel_hit   = cmd.run_rel && valid_s1 && busy_q[pos_s1]
			&& (rd_q.owner == req_q.proc_id);
		acc_ok    = cmd.acc_wr && (req_q.frame_no <= last_frame) && busy_q[req_q.frame_no];
	end

	// table write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = fresh;
		if (cmd.run_free && free_hit) begin
			we = 1'b1;
		end else if (eval_scan && cand && (take || clr)) begin
			we    = 1'b1;
			waddr = pos_s1;
			wdata = take ? fresh : '{owner: ent.owner, used_f: 1'b0, mod_f: ent.mod_f};
		end else if (acc_ok) begin
			we    = 1'b1;
			waddr = req_q.frame_no;
			wdata = '{owner: rd_q.owner, used_f: 1'b1, mod_f: rd_q.mod_f | req_q.is_write};
		end
		rd_addr = cmd.acc_rd ? req_q.frame_no : idx_q;
	end

	// frame table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// busy bits and clock hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			hand_q <= '0;
		end else begin
			if (cmd.run_free && free_hit) begin
				busy_q[idx_q] <= 1'b1;
			end else if (rel_hit) begin
				busy_q[pos_s1] <= 1'b0;
			end
			if (scan_end) begin
				hand_q <= pos_next;
			end
		end
	end

	// walk and stage control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= 1'b0;
			valid_s1    <= 1'b0;
			byp_valid_q <= 1'b0;
		end else begin
			byp_valid_q <= we;
			if (cmd.capture || (cmd.run_free && !free_hit && free_last)) begin
				issue_q  <= 1'b1;
				valid_s1 <= 1'b0;
			end else if (issue) begin
				valid_s1 <= 1'b1;
				issue_q  <= cmd.run_scan ? !scan_last_issue : !rel_last_issue;
			end else begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// walk payload, stage payload and pending result
	always_ff @(posedge clk) begin
		byp_addr_q <= waddr;
		byp_data_q <= wdata;
		if (cmd.capture) begin
			req_q   <= req;
			res_q   <= '{granted_frame: '0, status: cfr_pkg::STATUS_DONE, needs_swap_out: 1'b0};
			idx_q   <= '0;
			cnt_q   <= '0;
			sweep_q <= '0;
		end
		if (cmd.run_free) begin
			if (free_hit) begin
				res_q <= '{granted_frame: idx_q, status: cfr_pkg::STATUS_FREE,
					needs_swap_out: 1'b0};
			end else if (free_last) begin
				idx_q   <= hand_start;
				cnt_q   <= '0;
				sweep_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (issue) begin
			pos_s1   <= idx_q;
			sweep_s1 <= sweep_q;
			last_s1  <= cmd.run_scan ? scan_last_issue : rel_last_issue;
			if (cmd.run_scan) begin
				idx_q <= idx_wrap;
				if (cnt_q == last_frame) begin
					cnt_q   <= '0;
					sweep_q <= sweep_q + 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (victim) begin
			res_q <= '{granted_frame: pos_s1, status: cfr_pkg::STATUS_REPLACED,
				needs_swap_out: ent.mod_f};
		end else if (scan_end) begin
			res_q <= '{granted_frame: '0, status: cfr_pkg::STATUS_NO_VICT,
				needs_swap_out: 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	// status to controller
	always_comb begin
		sts.free_hit  = free_hit;
		sts.free_last = free_last;
		sts.scan_end  = scan_end;
		sts.rel_end   = cmd.run_rel && valid_s1 && last_s1;
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/core/clock_frame_replacement.sv]
// top level of the clock frame replacement block: configuration, controller and datapath
// access reads, then writes its entry; unused kind goes to response; release walks all 64 frames
// fault with free frame: search up from frame 0 to the lowest free one; fault with replacement:
// free search of the n active frames, up to four sweeps from the hand, one frame visit per cycle
// through the table read port; next transaction accepted the cycle after the response loads
// reset clears busy bits, clock hand and config (plain clock, 64 frames); table entries are not cleared
module clock_frame_replacement (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  cfr_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output cfr_pkg::rsp_t                     rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                               replace_mode_q;
	logic [cfr_pkg::CFG_DATA_W-1:0]     frames_active_q;
	logic [cfr_pkg::CFG_DATA_W-1:0]     frames_cnt;
	logic [cfr_pkg::FRAME_W-1:0]        last_frame;
	cfr_pkg::cmd_t                      cmd;
	cfr_pkg::sts_t                      sts;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q  <= 1'b0;
			frames_active_q <= cfr_pkg::CFG_DATA_W'(cfr_pkg::NUM_FRAMES);
		end else if (cfg_valid) begin
			case (cfg_index)
				cfr_pkg::CFG_REPLACE_MODE:  replace_mode_q  <= cfg_data[0];
				cfr_pkg::CFG_FRAMES_ACTIVE: frames_active_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// active frame count clamped to 1..NUM_FRAMES
	always_comb begin
		if (frames_active_q == '0) begin
			frames_cnt = cfr_pkg::CFG_DATA_W'(1);
		end else if (frames_active_q > cfr_pkg::CFG_DATA_W'(cfr_pkg::NUM_FRAMES)) begin
			frames_cnt = cfr_pkg::CFG_DATA_W'(cfr_pkg::NUM_FRAMES);
		end else begin
			frames_cnt = frames_active_q;
		end
		last_frame = cfr_pkg::FRAME_W'(frames_cnt - 1'b1);
	end

	cfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req.kind),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req          (req),
		.replace_mode (replace_mode_q),
		.last_frame   (last_frame),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp)
	);

	// one transaction in flight: an accepted request closes the request side
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a transaction was in flight");

	// a failed replacement grants nothing and swaps nothing
	a_no_victim_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == cfr_pkg::STATUS_NO_VICT)
		|-> (rsp.granted_frame == '0) && !rsp.needs_swap_out)
		else $error("no-victim response carries a frame or swap flag");

	// only replacement can require a swap out
	a_swap_only_replaced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.needs_swap_out |-> rsp.status == cfr_pkg::STATUS_REPLACED)
		else $error("swap out flagged on a response that replaced nothing");

endmodule

[bench/clock_frame_replacement_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the clock frame replacement block
module clock_frame_replacement_tb;
	import cfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int LATENCY_MAX    = 5 * NUM_FRAMES + 4;
	localparam int REQ_W          = $bits(req_t);

	// request kind with no operation behind it
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// traffic shaping
	int unsigned          send_idle_pct = 0;
	int unsigned          rsp_stall_pct = 0;
	logic                 hold_rsp      = 1'b0;
	logic [PROC_BITS-1:0] proc_pool [4];

	// frame table as the testbench sees it
	logic                  fr_busy  [NUM_FRAMES];
	logic                  fr_used  [NUM_FRAMES];
	logic                  fr_dirty [NUM_FRAMES];
	logic [PROC_BITS-1:0]  fr_owner [NUM_FRAMES];
	int unsigned           hand_pos   = 0;
	logic                  mode_cfg   = 1'b0;
	logic [CFG_DATA_W-1:0] frames_cfg = 7'd64;

	rsp_t        due_rsp [$];
	int unsigned error_count  = 0;
	int unsigned quiet_cycles = 0;

	clock_frame_replacement i_dut (
		.clk, .arst_n,
		.req_valid, .req_ready, .req,
		.rsp_valid, .rsp_ready, .rsp,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// frame count after clamping
	function automatic int unsigned live_frames();
		if (frames_cfg == 0)
			return 1;
		if (frames_cfg > NUM_FRAMES)
			return NUM_FRAMES;
		return frames_cfg;
	endfunction

	// apply one transaction to the frame table and work out its response
	function automatic rsp_t frame_table_step(input req_t r);
		rsp_t        o;
		int unsigned n, pos, step;
		bit          found, take;
		o     = '0;
		n     = live_frames();
		found = 1'b0;
		case (r.kind)
			KIND_ACCESS: begin
				if (r.frame_no < n && fr_busy[r.frame_no]) begin
					fr_used[r.frame_no] = 1'b1;
					if (r.is_write)
						fr_dirty[r.frame_no] = 1'b1;
				end
			end
			KIND_FAULT: begin
				// lowest free frame wins
				for (int i = 0; i < n && !found; i++) begin
					if (!fr_busy[i]) begin
						fr_busy[i]      = 1'b1;
						fr_used[i]      = 1'b0;
						fr_dirty[i]     = 1'b0;
						fr_owner[i]     = r.proc_id;
						o.granted_frame = FRAME_W'(i);
						o.status        = STATUS_FREE;
						found           = 1'b1;
					end
				end
				// rotating hand over own frames, four sweeps at most
				pos = (hand_pos < n) ? hand_pos : 0;
				for (step = 0; step < 4 * n && !found; step++) begin
					take = 1'b0;
					if (fr_busy[pos] && fr_owner[pos] == r.proc_id) begin
						if (!mode_cfg || (step / n) % 2 == 1) begin
							if (!fr_used[pos] && (!mode_cfg || fr_dirty[pos]))
								take = 1'b1;
							else
								fr_used[pos] = 1'b0;
						end else if (!fr_used[pos] && !fr_dirty[pos]) begin
							take = 1'b1;
						end
					end
					if (take) begin
						o.granted_frame  = FRAME_W'(pos);
						o.status         = STATUS_REPLACED;
						o.needs_swap_out = fr_dirty[pos];
						fr_used[pos]     = 1'b0;
						fr_dirty[pos]    = 1'b0;
						hand_pos         = (pos + 1 < n) ? pos + 1 : 0;
						found            = 1'b1;
					end else begin
						pos = (pos + 1 < n) ? pos + 1 : 0;
					end
				end
				if (!found) begin
					hand_pos = pos;
					o.status = STATUS_NO_VICT;
				end
			end
			KIND_RELEASE: begin
				for (int i = 0; i < NUM_FRAMES; i++) begin
					if (fr_busy[i] && fr_owner[i] == r.proc_id) begin
						fr_busy[i]  = 1'b0;
						fr_used[i]  = 1'b0;
						fr_dirty[i] = 1'b0;
						fr_owner[i] = '0;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t make_req(input logic [1:0] kind, input logic [PROC_BITS-1:0] pid,
			input int unsigned frame, input logic wr);
		req_t r;
		r.kind     = kind;
		r.proc_id  = pid;
		r.frame_no = FRAME_W'(frame);
		r.is_write = wr;
		return r;
	endfunction

	// mostly faults and accesses to active frames, some releases and noise
	function automatic req_t random_item();
		int unsigned          roll;
		logic [PROC_BITS-1:0] pid;
		req_t                 r;
		roll = $urandom_range(99);
		pid  = proc_pool[$urandom_range(3)];
		if (roll < 40)
			return make_req(KIND_FAULT, pid, $urandom_range(63), 1'($urandom_range(1)));
		if (roll < 82) begin
			if ($urandom_range(7) == 0)
				return make_req(KIND_ACCESS, pid, $urandom_range(63),
					1'($urandom_range(1)));
			return make_req(KIND_ACCESS, pid, $urandom_range(live_frames() - 1),
				1'($urandom_range(1)));
		end
		if (roll < 90)
			return make_req(KIND_RELEASE, pid, $urandom_range(63), 1'($urandom_range(1)));
		r = REQ_W'($urandom);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		error_count++;
	endtask

	// offer one request, valid stays up for the next one unless an idle gap follows
	task automatic send_item(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic repl_mode, input logic [CFG_DATA_W-1:0] frames);
		write_reg(CFG_REPLACE_MODE, {{(CFG_DATA_W-1){1'b0}}, repl_mode});
		write_reg(CFG_FRAMES_ACTIVE, frames);
		cfg_valid <= 1'b0;
	endtask

	// one edge first so the monitor has logged the last accepted request
	task automatic wait_responses_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_rsp.size() != 0)
			@(posedge clk);
	endtask

	// plain clock: free grants, inactive and free frame accesses, replacement, no victim
	task automatic test_plain_clock_directed();
		set_config(1'b0, 7'd3);
		send_item(make_req(KIND_SPARE, 8'hAA, 63, 1'b1));
		send_item(make_req(KIND_ACCESS, 8'h00, 0, 1'b1));
		send_item(make_req(KIND_FAULT, 8'h00, 0, 1'b0));
		send_item(make_req(KIND_FAULT, 8'hFF, 63, 1'b1));
		send_item(make_req(KIND_FAULT, 8'h00, 0, 1'b0));
		send_item(make_req(KIND_ACCESS, 8'h00, 63, 1'b1));
		send_item(make_req(KIND_ACCESS, 8'h00, 0, 1'b1));
		send_item(make_req(KIND_FAULT, 8'h00, 0, 1'b0));
		send_item(make_req(KIND_FAULT, 8'h00, 0, 1'b0));
		send_item(make_req(KIND_FAULT, 8'h55, 0, 1'b0));
		send_item(make_req(KIND_RELEASE, 8'hFF, 0, 1'b0));
		send_item(make_req(KIND_FAULT, 8'h55, 0, 1'b0));
		send_item(make_req(KIND_RELEASE, 8'h00, 0, 1'b0));
		wait_responses_done();
	endtask

	// enhanced clock: zero frame count, hand past the active range, dirty victims
	task automatic test_enhanced_clock_directed();
		set_config(1'b1, 7'd0);
		send_item(make_req(KIND_FAULT, 8'h81, 0, 1'b0));
		send_item(make_req(KIND_ACCESS, 8'h81, 0, 1'b0));
		send_item(make_req(KIND_FAULT, 8'h81, 0, 1'b0));
		send_item(make_req(KIND_ACCESS, 8'h81, 0, 1'b1));
		send_item(make_req(KIND_FAULT, 8'h81, 0, 1'b0));
		wait_responses_done();
		set_config(1'b1, 7'd2);
		send_item(make_req(KIND_FAULT, 8'h81, 0, 1'b0));
		send_item(make_req(KIND_ACCESS, 8'h55, 1, 1'b1));
		send_item(make_req(KIND_FAULT, 8'h55, 0, 1'b0));
		send_item(make_req(KIND_RELEASE, 8'h81, 0, 1'b0));
		send_item(make_req(KIND_RELEASE, 8'h55, 0, 1'b0));
		send_item(make_req(KIND_SPARE, 8'h7E, 42, 1'b0));
		wait_responses_done();
	endtask

	// random traffic from a small set of processes under one setting
	task automatic test_random_mix(input logic repl_mode, input logic [CFG_DATA_W-1:0] frames,
			input int unsigned idle_pct, input int unsigned stall_pct, input int unsigned count);
		set_config(repl_mode, frames);
		foreach (proc_pool[i])
			proc_pool[i] = PROC_BITS'($urandom_range(255));
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count)
			send_item(random_item());
		wait_responses_done();
	endtask

	// receiver holds off long enough for the request side to back up
	task automatic test_rsp_backpressure();
		set_config(1'b0, 7'd8);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		fork
			begin
				hold_rsp <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp <= 1'b0;
			end
			repeat (40) send_item(random_item());
		join
		wait_responses_done();
	endtask

	// response side ready pattern
	always @(posedge clk) begin
		rsp_ready <= arst_n && !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
	end

	// track transactions, check responses, watch for a hang
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REPLACE_MODE)
					mode_cfg = cfg_data[0];
				else
					frames_cfg = cfg_data;
			end
			if (req_valid && req_ready)
				due_rsp.push_back(frame_table_step(req));
			if (rsp_valid && rsp_ready) begin
				if (due_rsp.size() == 0) begin
					report_mismatch("response with none outstanding", rsp, 0);
				end else begin
					want = due_rsp.pop_front();
					if (rsp.granted_frame !== want.granted_frame)
						report_mismatch("granted_frame", rsp.granted_frame, want.granted_frame);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.needs_swap_out !== want.needs_swap_out)
						report_mismatch("needs_swap_out", rsp.needs_swap_out,
							want.needs_swap_out);
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		foreach (fr_busy[i]) begin
			fr_busy[i]  = 1'b0;
			fr_used[i]  = 1'b0;
			fr_dirty[i] = 1'b0;
			fr_owner[i] = '0;
		end
		foreach (proc_pool[i])
			proc_pool[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_clock_directed();
		test_enhanced_clock_directed();
		test_random_mix(1'b0, 7'd8, 0, 0, 200);
		test_random_mix(1'b1, 7'd127, 74, 0, 200);
		test_random_mix(1'b0, 7'd1, 0, 74, 140);
		test_random_mix(1'b1, 7'd4, 27, 27, 220);
		test_random_mix(1'b0, 7'd64, 0, 0, 180);
		test_random_mix(1'b1, CFG_DATA_W'($urandom_range(64, 1)), 74, 0, 200);
		test_random_mix(1'b1, 7'd16, 0, 74, 200);
		test_random_mix(1'b0, 7'd3, 27, 27, 220);
		test_random_mix(1'b1, 7'd0, 0, 0, 100);
		test_rsp_backpressure();

		wait_responses_done();
		repeat (LATENCY_MAX) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
